>>> sv/tsm_pkg.sv
// shared types, constants and arithmetic helpers for the tandem swash mixer
package tsm_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int FRACTION_BITS = 14;
    localparam int GAIN_WIDTH    = 16;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_COUNT     = 8;
    localparam int CFG_IDX_W     = $clog2(CFG_COUNT);
    // internal word, holds every intermediate value with headroom
    localparam int W             = SAMPLE_WIDTH + 10;
    localparam int PW            = W + GAIN_WIDTH;
    localparam int NSTG          = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_ROLL_YAW  = 3'd1,
        REG_PITCH     = 3'd2,
        REG_COLL      = 3'd3,
        REG_DCP_GAINS = 3'd4,
        REG_DCP_SPLIT = 3'd5,
        REG_REAR_TILT = 3'd6,
        REG_CCPM      = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_GAIN  = 2'd0,
        MODE_PHASE = 2'd1,
        MODE_COPY  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam longint Q30_COS30 = 64'sd929887697;
    localparam longint Q30_HALF  = 64'sd536870912;
    localparam longint Q30_COS18 = 64'sd1021189158;
    localparam longint Q30_SIN18 = 64'sd331804461;
    localparam longint Q30_COS48 = 64'sd718473512;
    localparam longint Q30_SINM48 = -64'sd797945670;
    localparam int     KSH = 30 - FRACTION_BITS;
    localparam longint KRND = 64'sd1 <<< (KSH - 1);

    localparam logic signed [GAIN_WIDTH-1:0] K_COS30  = GAIN_WIDTH'((Q30_COS30 + KRND) >>> KSH);
    localparam logic signed [GAIN_WIDTH-1:0] K_HALF   = GAIN_WIDTH'((Q30_HALF + KRND) >>> KSH);
    localparam logic signed [GAIN_WIDTH-1:0] K_COS18  = GAIN_WIDTH'((Q30_COS18 + KRND) >>> KSH);
    localparam logic signed [GAIN_WIDTH-1:0] K_SIN18  = GAIN_WIDTH'((Q30_SIN18 + KRND) >>> KSH);
    localparam logic signed [GAIN_WIDTH-1:0] K_COS48  = GAIN_WIDTH'((Q30_COS48 + KRND) >>> KSH);
    localparam logic signed [GAIN_WIDTH-1:0] K_SINM48 = GAIN_WIDTH'((Q30_SINM48 + KRND) >>> KSH);

    localparam logic signed [PW-1:0] MUL_RND = PW'(1) <<< (FRACTION_BITS - 1);
    localparam logic signed [W-1:0]  SAT_MAX = W'((1 <<< (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [W-1:0]  SAT_MIN = -SAT_MAX - W'(1);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] roll_cmd;
        logic signed [SAMPLE_WIDTH-1:0] pitch_cmd;
        logic signed [SAMPLE_WIDTH-1:0] yaw_cmd;
        logic signed [SAMPLE_WIDTH-1:0] collective_cmd;
    } t_cmd;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] front_a;
        logic signed [SAMPLE_WIDTH-1:0] front_b;
        logic signed [SAMPLE_WIDTH-1:0] front_c;
        logic signed [SAMPLE_WIDTH-1:0] front_yaw;
        logic signed [SAMPLE_WIDTH-1:0] rear_a;
        logic signed [SAMPLE_WIDTH-1:0] rear_b;
        logic signed [SAMPLE_WIDTH-1:0] rear_c;
        logic signed [SAMPLE_WIDTH-1:0] rear_yaw;
        logic                           mode_supported;
        logic                           saturated;
    } t_servo;

    typedef struct packed {
        logic                           hit;
        logic signed [SAMPLE_WIDTH-1:0] val;
    } t_sat;

    // q-format product, round half up
    function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
                                                 input logic signed [GAIN_WIDTH-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return W'((p + MUL_RND) >>> FRACTION_BITS);
    endfunction

    function automatic t_sat sat(input logic signed [W-1:0] x);
        t_sat s;
        s.hit = 1'b0;
        s.val = SAMPLE_WIDTH'(x);
        if (x > SAT_MAX) begin
            s.hit = 1'b1;
            s.val = SAMPLE_WIDTH'(SAT_MAX);
        end else if (x < SAT_MIN) begin
            s.hit = 1'b1;
            s.val = SAMPLE_WIDTH'(SAT_MIN);
        end
        return s;
    endfunction

endpackage

>>> sv/tsm_if.sv
// beat channels of the mixer: commands, servo results and register writes
interface tsm_cmd_if import tsm_pkg::*; ();
    logic valid;
    logic ready;
    t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsm_servo_if import tsm_pkg::*; ();
    logic   valid;
    logic   ready;
    t_servo data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsm_cfg_if import tsm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/tandem_rotor_swash_mixer.sv
// tandem rotor swashplate mixer, pipelined top level
// One command beat in gives one servo beat out. The beat is taken into the
// first of eight pipeline stages and passes through the rest to the output
// register, from which the servo beat is offered. That makes nine register
// levels in all. Each stage has one registered multiply or add level, so a new
// command beat is taken every cycle unless a stall reaches the input. Each stage
// holds its beat until the next one frees up. Backpressure on the servo side
// therefore stalls only as far back as needed. The input keeps flowing while
// empty stages are left to fill, and it stalls once all nine levels hold a beat.
// Registers are written through the config channel, which is always ready;
// write them only while the pipeline is empty.
module tandem_rotor_swash_mixer import tsm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tsm_cmd_if.sink     i_cmd,
    tsm_cfg_if.sink     i_cfg,
    tsm_servo_if.source o_servo
);

    typedef struct packed {
        logic signed [W-1:0] pitch;
        logic signed [W-1:0] yaw;
        logic signed [W-1:0] r;
        logic signed [W-1:0] y;
        logic signed [W-1:0] cs;
        logic signed [W-1:0] p0;
        logic signed [W-1:0] rc;
        logic signed [W-1:0] ph;
        logic signed [W-1:0] pf;
        logic signed [W-1:0] pr;
        logic signed [W-1:0] d;
        logic signed [W-1:0] cpf;
        logic signed [W-1:0] tq;
        logic signed [W-1:0] dsf;
        logic signed [W-1:0] dsr;
        logic signed [W-1:0] cpr;
        logic signed [W-1:0] tf;
        logic signed [W-1:0] tr;
        logic signed [W-1:0] rf;
        logic signed [W-1:0] rr;
        logic signed [W-1:0] m_pc;
        logic signed [W-1:0] m_rs;
        logic signed [W-1:0] m_ps;
        logic signed [W-1:0] m_rc;
        logic signed [W-1:0] m_qc;
        logic signed [W-1:0] m_ss;
        logic signed [W-1:0] m_qs;
        logic signed [W-1:0] m_sc;
        logic signed [W-1:0] p1;
        logic signed [W-1:0] r1;
        logic signed [W-1:0] p2;
        logic signed [W-1:0] r2;
        logic signed [W-1:0] c1;
        logic signed [W-1:0] c2;
    } t_pipe;

    // configuration registers
    logic [1:0]                    r_mode;
    logic [CFG_DATA_W-1:0]         r_roll_yaw;
    logic [CFG_DATA_W-1:0]         r_pitch;
    logic signed [GAIN_WIDTH-1:0]  r_coll;
    logic [CFG_DATA_W-1:0]         r_dcp_gains;
    logic [CFG_DATA_W-1:0]         r_dcp_split;
    logic signed [GAIN_WIDTH-1:0]  r_rear_tilt;
    logic signed [GAIN_WIDTH-1:0]  r_ccpm;

    // pipeline
    t_pipe        r_st [NSTG];
    t_pipe        n_st [NSTG];
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;
    logic         en_o;
    logic         r_ovld;
    t_servo       r_out;
    t_servo       n_out;

    logic signed [GAIN_WIDTH-1:0] g_roll, g_yaw, g_prange, g_elev;
    logic signed [GAIN_WIDTH-1:0] g_dcp, g_torque, g_front, g_rear;

    assign g_roll   = signed'(r_roll_yaw[31:16]);
    assign g_yaw    = signed'(r_roll_yaw[15:0]);
    assign g_prange = signed'(r_pitch[31:16]);
    assign g_elev   = signed'(r_pitch[15:0]);
    assign g_dcp    = signed'(r_dcp_gains[31:16]);
    assign g_torque = signed'(r_dcp_gains[15:0]);
    assign g_front  = signed'(r_dcp_split[31:16]);
    assign g_rear   = signed'(r_dcp_split[15:0]);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_GAIN;
            r_roll_yaw  <= 32'h4000_4000;
            r_pitch     <= 32'h4000_4000;
            r_coll      <= 16'sh4000;
            r_dcp_gains <= '0;
            r_dcp_split <= 32'h4000_4000;
            r_rear_tilt <= 16'sh4000;
            r_ccpm      <= 16'sh4000;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_MODE:      r_mode      <= i_cfg.data[1:0];
                REG_ROLL_YAW:  r_roll_yaw  <= i_cfg.data;
                REG_PITCH:     r_pitch     <= i_cfg.data;
                REG_COLL:      r_coll      <= signed'(i_cfg.data[15:0]);
                REG_DCP_GAINS: r_dcp_gains <= i_cfg.data;
                REG_DCP_SPLIT: r_dcp_split <= i_cfg.data;
                REG_REAR_TILT: r_rear_tilt <= signed'(i_cfg.data[15:0]);
                REG_CCPM:      r_ccpm      <= signed'(i_cfg.data[15:0]);
                default:       ;
            endcase
        end
    end

    // per stage advance: a stage moves when it is empty or its successor moves
    assign en_o = !r_ovld || o_servo.ready;
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || en_o;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end
    assign i_cmd.ready = en[0];

    always_comb begin
        // stage 0: first-level products of the raw commands
        n_st[0]       = r_st[0];
        n_st[0].pitch = W'(i_cmd.data.pitch_cmd);
        n_st[0].yaw   = W'(i_cmd.data.yaw_cmd);
        n_st[0].r     = mulq(W'(i_cmd.data.roll_cmd), g_roll);
        n_st[0].y     = mulq(W'(i_cmd.data.yaw_cmd), g_yaw);
        n_st[0].cs    = mulq(W'(i_cmd.data.collective_cmd), r_coll);
        n_st[0].p0    = mulq(W'(i_cmd.data.pitch_cmd), g_prange);
        n_st[0].rc    = mulq(W'(i_cmd.data.roll_cmd), K_COS30);
        n_st[0].ph    = mulq(W'(i_cmd.data.pitch_cmd), K_HALF);

        // stage 1: front pitch after elevator gain
        n_st[1]    = r_st[0];
        n_st[1].pf = mulq(r_st[0].p0, g_elev);

        // stage 2: rear pitch, differential collective, ccpm on front pitch
        n_st[2]     = r_st[1];
        n_st[2].pr  = mulq(r_st[1].pf, r_rear_tilt);
        n_st[2].d   = mulq(r_st[1].pf, g_dcp);
        n_st[2].cpf = mulq(r_st[1].pf, r_ccpm);

        // stage 3: torque comp, dcp shares and ccpm on rear pitch
        n_st[3]     = r_st[2];
        n_st[3].tq  = mulq(r_st[2].d, g_torque);
        n_st[3].dsf = mulq(r_st[2].d, g_front);
        n_st[3].dsr = mulq(r_st[2].d, g_rear);
        n_st[3].cpr = mulq(r_st[2].pr, r_ccpm);

        // stage 4: collective and roll sums per rotor
        n_st[4]    = r_st[3];
        n_st[4].tf = r_st[3].cs + r_st[3].dsf;
        n_st[4].tr = r_st[3].cs - r_st[3].dsr;
        n_st[4].rf = r_st[3].r + r_st[3].y + r_st[3].tq;
        n_st[4].rr = r_st[3].r - r_st[3].y - r_st[3].tq;

        // stage 5: phase rotation products
        n_st[5]      = r_st[4];
        n_st[5].m_pc = mulq(r_st[4].pf, K_COS18);
        n_st[5].m_rs = mulq(r_st[4].rf, K_SIN18);
        n_st[5].m_ps = mulq(r_st[4].pf, K_SIN18);
        n_st[5].m_rc = mulq(r_st[4].rf, K_COS18);
        n_st[5].m_qc = mulq(r_st[4].pr, K_COS48);
        n_st[5].m_ss = mulq(r_st[4].rr, K_SINM48);
        n_st[5].m_qs = mulq(r_st[4].pr, K_SINM48);
        n_st[5].m_sc = mulq(r_st[4].rr, K_COS48);

        // stage 6: rotated pitch and roll
        n_st[6]    = r_st[5];
        n_st[6].p1 = r_st[5].m_pc - r_st[5].m_rs;
        n_st[6].r1 = r_st[5].m_ps + r_st[5].m_rc;
        n_st[6].p2 = r_st[5].m_qc - r_st[5].m_ss;
        n_st[6].r2 = r_st[5].m_qs + r_st[5].m_sc;

        // stage 7: ccpm on rotated pitch
        n_st[7]    = r_st[6];
        n_st[7].c1 = mulq(r_st[6].p1, r_ccpm);
        n_st[7].c2 = mulq(r_st[6].p2, r_ccpm);
    end

    // final stage: servo sums, saturation and mode select
    always_comb begin
        t_pipe               s;
        logic signed [W-1:0] v [8];
        t_sat                q [8];
        s = r_st[NSTG-1];
        for (int k = 0; k < 8; k++) begin
            v[k] = '0;
        end
        n_out = '0;
        unique case (t_mode'(r_mode))
            MODE_GAIN: begin
                v[0] = s.rf + s.cpf + s.tf;
                v[1] = s.rf - s.cpf - s.tf;
                v[2] = s.tf - s.pf;
                v[4] = -s.tr - s.cpr - s.rr;
                v[5] = s.tr + s.cpr - s.rr;
                v[6] = -s.tr + s.pr;
            end
            MODE_PHASE: begin
                v[0] = -s.r1 + s.c1 + s.tf;
                v[1] = -s.r1 - s.c1 - s.tf;
                v[2] = s.tf - s.p1;
                v[4] = s.tr - s.c2 + s.r2;
                v[5] = -s.tr + s.c2 + s.r2;
                v[6] = s.tr + s.p2;
            end
            MODE_COPY: begin
                v[0] = s.cs - s.pitch;
                v[1] = -s.cs + s.rc - s.ph;
                v[2] = s.cs + s.rc + s.ph;
                v[3] = -s.yaw;
                for (int k = 0; k < 4; k++) begin
                    v[4+k] = v[k];
                end
            end
            MODE_NONE: ;
            default: ;
        endcase
        for (int k = 0; k < 8; k++) begin
            q[k] = sat(v[k]);
        end
        if (t_mode'(r_mode) != MODE_NONE) begin
            n_out.front_a        = q[0].val;
            n_out.front_b        = q[1].val;
            n_out.front_c        = q[2].val;
            n_out.front_yaw      = q[3].val;
            n_out.rear_a         = q[4].val;
            n_out.rear_b         = q[5].val;
            n_out.rear_c         = q[6].val;
            n_out.rear_yaw       = q[7].val;
            n_out.mode_supported = 1'b1;
            n_out.saturated      = q[0].hit | q[1].hit | q[2].hit | q[3].hit |
                                   q[4].hit | q[5].hit | q[6].hit | q[7].hit;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_cmd.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (en_o) begin
                r_ovld <= r_vld[NSTG-1];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (en_o) begin
            r_out <= n_out;
        end
    end

    assign o_servo.valid = r_ovld;
    assign o_servo.data  = r_out;

endmodule

>>> sim/tb_tandem_rotor_swash_mixer.sv
// self-checking testbench for the tandem rotor swashplate mixer
`timescale 1ns / 1ps

module tb_tandem_rotor_swash_mixer;
    import tsm_pkg::*;

    localparam longint QBOUND = 64'sd4294967295;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk;
    logic i_rst_n;

    tsm_cmd_if   cmd_ch ();
    tsm_servo_if servo_ch ();
    tsm_cfg_if   cfg_ch ();

    tandem_rotor_swash_mixer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch.sink),
        .i_cfg   (cfg_ch.sink),
        .o_servo (servo_ch.source)
    );

    // register copies held by the predictor
    logic [31:0] shadow_regs [CFG_COUNT];

    t_servo servo_queue [$];
    int     error_count;
    int     sent_beats;

    // idling control: percentage of idle cycles, zero during the quiet stretch
    int  idle_pct;
    bit  hold_off;

    // directed table
    typedef struct {
        t_cmd   cmd;
        bit     known;
        t_servo result;
    } t_row;
    t_row rows [$];

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------
    // arithmetic of the mix, widened to longint
    // ---------------------------------------------------------------
    function automatic longint clip_wide(input longint x);
        if (x > QBOUND) return QBOUND;
        if (x < -QBOUND) return -QBOUND;
        return x;
    endfunction

    // round half up, arithmetic shift is floor for signed longint
    function automatic longint round_q(input longint x, input int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return clip_wide(round_q(clip_wide(a) * clip_wide(b), FRACTION_BITS));
    endfunction

    function automatic longint hi_half(input logic [31:0] r);
        return longint'($signed(r[31:16]));
    endfunction

    function automatic longint lo_half(input logic [31:0] r);
        return longint'($signed(r[15:0]));
    endfunction

    function automatic logic signed [15:0] clip_servo(input longint x, inout bit hit);
        if (x > 32767) begin
            hit = 1'b1;
            return 16'sh7fff;
        end
        if (x < -32768) begin
            hit = 1'b1;
            return 16'sh8000;
        end
        return 16'(x);
    endfunction

    function automatic t_servo mix_servos(input t_cmd c);
        t_servo o;
        longint v [8];
        longint roll, pitch, yaw, coll, ccpm;
        longint r, y, pf, pr, d, tq, cs, tf, tr, rf, rr;
        longint p1, r1, p2, r2, c1, c2, rc, ph;
        bit hit;
        t_mode mode;
        roll  = longint'(c.roll_cmd);
        pitch = longint'(c.pitch_cmd);
        yaw   = longint'(c.yaw_cmd);
        coll  = longint'(c.collective_cmd);
        mode  = t_mode'(shadow_regs[REG_MODE][1:0]);
        hit   = 1'b0;
        o     = '0;
        foreach (v[k]) v[k] = 0;
        if (mode == MODE_GAIN || mode == MODE_PHASE) begin
            ccpm = lo_half(shadow_regs[REG_CCPM]);
            r  = qmul(roll, hi_half(shadow_regs[REG_ROLL_YAW]));
            y  = qmul(yaw, lo_half(shadow_regs[REG_ROLL_YAW]));
            pf = qmul(qmul(pitch, hi_half(shadow_regs[REG_PITCH])),
                      lo_half(shadow_regs[REG_PITCH]));
            pr = qmul(pf, lo_half(shadow_regs[REG_REAR_TILT]));
            d  = qmul(pf, hi_half(shadow_regs[REG_DCP_GAINS]));
            tq = qmul(d, lo_half(shadow_regs[REG_DCP_GAINS]));
            cs = qmul(coll, lo_half(shadow_regs[REG_COLL]));
            tf = clip_wide(cs + qmul(d, hi_half(shadow_regs[REG_DCP_SPLIT])));
            tr = clip_wide(cs - qmul(d, lo_half(shadow_regs[REG_DCP_SPLIT])));
            rf = clip_wide(r + y + tq);
            rr = clip_wide(r - y - tq);
            if (mode == MODE_GAIN) begin
                c1 = qmul(ccpm, pf);
                c2 = qmul(ccpm, pr);
                v[0] = rf + c1 + tf;
                v[1] = rf - c1 - tf;
                v[2] = tf - pf;
                v[4] = -tr - c2 - rr;
                v[5] = tr + c2 - rr;
                v[6] = -tr + pr;
            end else begin
                // each rotor's pitch/roll pair turned by its phase angle
                p1 = clip_wide(qmul(pf, K_COS18) - qmul(rf, K_SIN18));
                r1 = clip_wide(qmul(pf, K_SIN18) + qmul(rf, K_COS18));
                p2 = clip_wide(qmul(pr, K_COS48) - qmul(rr, K_SINM48));
                r2 = clip_wide(qmul(pr, K_SINM48) + qmul(rr, K_COS48));
                c1 = qmul(ccpm, p1);
                c2 = qmul(ccpm, p2);
                v[0] = -r1 + c1 + tf;
                v[1] = -r1 - c1 - tf;
                v[2] = tf - p1;
                v[4] = tr - c2 + r2;
                v[5] = -tr + c2 + r2;
                v[6] = tr + p2;
            end
            o.front_a   = clip_servo(v[0], hit);
            o.front_b   = clip_servo(v[1], hit);
            o.front_c   = clip_servo(v[2], hit);
            o.front_yaw = clip_servo(v[3], hit);
            o.rear_a    = clip_servo(v[4], hit);
            o.rear_b    = clip_servo(v[5], hit);
            o.rear_c    = clip_servo(v[6], hit);
            o.rear_yaw  = clip_servo(v[7], hit);
            o.mode_supported = 1'b1;
        end else if (mode == MODE_COPY) begin
            cs = qmul(coll, lo_half(shadow_regs[REG_COLL]));
            rc = qmul(roll, K_COS30);
            ph = qmul(pitch, K_HALF);
            o.front_a   = clip_servo(cs - pitch, hit);
            o.front_b   = clip_servo(-cs + rc - ph, hit);
            o.front_c   = clip_servo(cs + rc + ph, hit);
            o.front_yaw = clip_servo(-yaw, hit);
            o.rear_a    = o.front_a;
            o.rear_b    = o.front_b;
            o.rear_c    = o.front_c;
            o.rear_yaw  = o.front_yaw;
            o.mode_supported = 1'b1;
        end
        o.saturated = hit;
        return o;
    endfunction

    // ---------------------------------------------------------------
    // reporting
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------
    // one write beat, then the channel is left idle before the task returns
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        shadow_regs[idx] = value & ((idx == REG_MODE) ? 32'h3 :
                           (idx == REG_COLL || idx == REG_REAR_TILT || idx == REG_CCPM)
                           ? 32'hffff : 32'hffff_ffff);
        @(posedge i_clk);
    endtask

    // random gaps first, then one beat held until taken
    task automatic send_cmd(input t_cmd c, input bit known, input t_servo want);
        while ($urandom_range(99) < idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        // the prediction joins the queue at acceptance, before the result can appear
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        servo_queue.push_back(known ? want : mix_servos(c));
        sent_beats++;
    endtask

    task automatic send_rows();
        foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].known, rows[i].result);
        rows.delete();
    endtask

    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (servo_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        c.roll_cmd       = rand_sample();
        c.pitch_cmd      = rand_sample();
        c.yaw_cmd        = rand_sample();
        c.collective_cmd = rand_sample();
        return c;
    endfunction

    // gains of magnitude at most 0.625 most of the time, so most beats stay in range
    function automatic logic [15:0] rand_gain();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom_range(16'h5000)) - 16'h2800;
        endcase
    endfunction

    task automatic random_config(input t_mode mode);
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_ROLL_YAW, {rand_gain(), rand_gain()});
        write_reg(REG_PITCH, {rand_gain(), rand_gain()});
        write_reg(REG_COLL, 32'(rand_gain()));
        write_reg(REG_DCP_GAINS, {rand_gain(), rand_gain()});
        write_reg(REG_DCP_SPLIT, {rand_gain(), rand_gain()});
        write_reg(REG_REAR_TILT, 32'(rand_gain()));
        write_reg(REG_CCPM, 32'(rand_gain()));
    endtask

    function automatic t_cmd make_cmd(input logic [15:0] r, input logic [15:0] p,
                                      input logic [15:0] y, input logic [15:0] c);
        t_cmd m;
        m.roll_cmd       = r;
        m.pitch_cmd      = p;
        m.yaw_cmd        = y;
        m.collective_cmd = c;
        return m;
    endfunction

    // ---------------------------------------------------------------
    // receiver: random stalls, the long hold-off and the check
    // ---------------------------------------------------------------
    initial begin
        servo_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            servo_ch.ready <= !hold_off && ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_servo got, want;
        if (i_rst_n && servo_ch.valid && servo_ch.ready) begin
            got = servo_ch.data;
            if (servo_queue.size() == 0) begin
                report_mismatch("servo beat with nothing expected", 0, 0);
            end else begin
                want = servo_queue.pop_front();
                if (got.front_a !== want.front_a)
                    report_mismatch("front_a", got.front_a, want.front_a);
                if (got.front_b !== want.front_b)
                    report_mismatch("front_b", got.front_b, want.front_b);
                if (got.front_c !== want.front_c)
                    report_mismatch("front_c", got.front_c, want.front_c);
                if (got.front_yaw !== want.front_yaw)
                    report_mismatch("front_yaw", got.front_yaw, want.front_yaw);
                if (got.rear_a !== want.rear_a)
                    report_mismatch("rear_a", got.rear_a, want.rear_a);
                if (got.rear_b !== want.rear_b)
                    report_mismatch("rear_b", got.rear_b, want.rear_b);
                if (got.rear_c !== want.rear_c)
                    report_mismatch("rear_c", got.rear_c, want.rear_c);
                if (got.rear_yaw !== want.rear_yaw)
                    report_mismatch("rear_yaw", got.rear_yaw, want.rear_yaw);
                if (got.mode_supported !== want.mode_supported)
                    report_mismatch("mode_supported", got.mode_supported,
                                    want.mode_supported);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
            end
        end
    end

    // ---------------------------------------------------------------
    // long hold-off: the receiver stops while the sender keeps offering
    // ---------------------------------------------------------------
    task automatic hold_receiver(input int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        t_servo zero_res, known_res, none_res;
        t_mode  mode;
        int     phase;
        error_count = 0;
        sent_beats  = 0;
        idle_pct    = 34;
        hold_off    = 1'b0;
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        shadow_regs[REG_MODE]      = 32'h0;
        shadow_regs[REG_ROLL_YAW]  = 32'h4000_4000;
        shadow_regs[REG_PITCH]     = 32'h4000_4000;
        shadow_regs[REG_COLL]      = 32'h4000;
        shadow_regs[REG_DCP_GAINS] = 32'h0;
        shadow_regs[REG_DCP_SPLIT] = 32'h4000_4000;
        shadow_regs[REG_REAR_TILT] = 32'h4000;
        shadow_regs[REG_CCPM]      = 32'h4000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows under reset values: zero in gives zero out
        zero_res = '0;
        zero_res.mode_supported = 1'b1;
        none_res = '0;
        rows.push_back('{make_cmd(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000),
                         1'b1, zero_res});
        // collective alone at unity gain lands on the three swash servos of each rotor
        known_res = zero_res;
        known_res.front_a = 16'sh1000;
        known_res.front_b = -16'sh1000;
        known_res.front_c = 16'sh1000;
        known_res.rear_a  = -16'sh1000;
        known_res.rear_b  = 16'sh1000;
        known_res.rear_c  = -16'sh1000;
        rows.push_back('{make_cmd(16'sh0000, 16'sh0000, 16'sh0000, 16'sh1000),
                         1'b1, known_res});
        rows.push_back('{make_cmd(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh0001, 16'shffff, 16'sh1234, 16'shedcb), 1'b0, zero_res});
        send_rows();
        wait_drained();

        // copy mix: the most negative yaw clips on the yaw servos
        write_reg(REG_MODE, 32'(MODE_COPY));
        known_res = zero_res;
        known_res.front_yaw = 16'sh7fff;
        known_res.rear_yaw  = 16'sh7fff;
        known_res.saturated = 1'b1;
        rows.push_back('{make_cmd(16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000),
                         1'b1, known_res});
        rows.push_back('{make_cmd(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh2000, 16'sh1000, 16'sh0100, 16'shc000), 1'b0, zero_res});
        send_rows();
        wait_drained();

        // unsupported mode: all zeros, flag clear
        write_reg(REG_MODE, 32'(MODE_NONE));
        rows.push_back('{make_cmd(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000), 1'b1, none_res});
        rows.push_back('{make_cmd(16'sh1111, 16'sh2222, 16'sh3333, 16'sh4444), 1'b1, none_res});
        send_rows();
        wait_drained();

        // phase mix with extreme gains
        write_reg(REG_MODE, 32'(MODE_PHASE));
        write_reg(REG_ROLL_YAW, 32'h7fff_8000);
        write_reg(REG_PITCH, 32'h8000_7fff);
        write_reg(REG_COLL, 32'h8000);
        write_reg(REG_DCP_GAINS, 32'h7fff_7fff);
        write_reg(REG_DCP_SPLIT, 32'h8000_8000);
        write_reg(REG_REAR_TILT, 32'h7fff);
        write_reg(REG_CCPM, 32'h8000);
        rows.push_back('{make_cmd(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh0400, 16'shfc00, 16'sh0200, 16'sh0800), 1'b0, zero_res});
        rows.push_back('{make_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff), 1'b0, zero_res});
        send_rows();
        wait_drained();

        // random phases: fresh settings, sometimes a quiet stretch or a hold-off
        for (phase = 0; phase < 24; phase++) begin
            mode = t_mode'((phase < 20) ? phase % 3 : $urandom_range(3));
            random_config(mode);
            idle_pct = (phase == 5) ? 0 : 34;
            fork
                if (phase == 3 || phase == 11) hold_receiver(200);
                for (int n = 0; n < 60; n++) send_cmd(rand_cmd(), 1'b0, zero_res);
            join
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_tandem_rotor_swash_mixer: done, clean");
        else
            $display("tb_tandem_rotor_swash_mixer: done, errors");
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("tb_tandem_rotor_swash_mixer: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
sv/tsm_pkg.sv
sv/tsm_if.sv
sv/tandem_rotor_swash_mixer.sv
sim/tb_tandem_rotor_swash_mixer.sv
